/* sv/gbfp_pkg.sv */
package gbfp_pkg;

    localparam int unsigned FrameLen   = 32;
    localparam int unsigned CountW     = $clog2(FrameLen);
    localparam int unsigned QueueDepth = 2;

    localparam logic [7:0] SyncV16    = 8'hD0;
    localparam logic [7:0] SyncV19    = 8'hD1;
    localparam logic [7:0] SyncTwo    = 8'hDD;
    localparam logic [7:0] LenByte    = 8'(FrameLen);
    localparam logic [7:0] Fix3dPlain = 8'd3;
    localparam logic [7:0] Fix3dAug   = 8'd7;
    localparam logic [7:0] Divisor    = 8'd100;

    // floor(x / 100) == (x * Div100Magic) >> Div100Shift for any 32-bit x
    localparam logic [31:0] Div100Magic = 32'h51EB_851F;
    localparam int unsigned Div100Shift = 37;

    localparam logic VerV16 = 1'b0;
    localparam logic VerV19 = 1'b1;

    localparam int unsigned AddrW  = 3;
    localparam logic        RegVer = 1'b0;

    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CKA     = 3'd4,
        PH_CKB     = 3'd5
    } t_phase;

    typedef struct packed {
        logic        version;
        logic        fix_3d;
        logic [31:0] lat;
        logic [31:0] lon;
        logic [31:0] alt;
        logic [31:0] speed;
        logic [31:0] course;
        logic [7:0]  sats;
        logic [31:0] utc;
    } t_frame;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

endpackage

/* sv/gbfp_if.sv */
interface gbfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface gbfp_result_if;
    logic               valid;
    logic               ready;
    logic               fix_3d;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic signed [25:0] altitude_m;
    logic signed [31:0] speed_cms;
    logic signed [25:0] course_deg;
    logic [7:0]         satellite_count;
    logic [31:0]        utc_word;

    modport source (
        output valid, output fix_3d, output latitude, output longitude,
        output altitude_m, output speed_cms, output course_deg,
        output satellite_count, output utc_word, input ready
    );
    modport sink (
        input valid, input fix_3d, input latitude, input longitude,
        input altitude_m, input speed_cms, input course_deg,
        input satellite_count, input utc_word, output ready
    );
endinterface

/* sv/gbfp_front.sv */
module gbfp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_version,
    gbfp_byte_if.sink            i_byte,
    input  logic                 i_space,
    output logic                 o_push,
    output gbfp_pkg::t_frame     o_frame
);

    gbfp_pkg::t_phase                r_phase, n_phase;
    logic [7:0]                      r_sum_a, n_sum_a;
    logic [7:0]                      r_sum_b, n_sum_b;
    logic [gbfp_pkg::CountW-1:0]     r_count, n_count;
    logic [7:0]                      r_store [gbfp_pkg::FrameLen];
    logic                            accept;
    logic [7:0]                      b;
    logic [7:0]                      sync1;

    assign i_byte.ready = i_space;
    assign accept       = i_byte.valid && i_space;
    assign b            = i_byte.rx_byte;
    assign sync1        = i_version ? gbfp_pkg::SyncV19 : gbfp_pkg::SyncV16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= gbfp_pkg::PH_SYNC1;
            r_sum_a <= '0;
            r_sum_b <= '0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && r_phase == gbfp_pkg::PH_PAYLOAD) begin
            r_store[r_count] <= b;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        n_count = r_count;
        o_push  = 1'b0;
        if (accept) begin
            unique case (r_phase)
                gbfp_pkg::PH_SYNC2: begin
                    if (b == gbfp_pkg::SyncTwo) begin
                        n_phase = gbfp_pkg::PH_LEN;
                    end else begin
                        n_phase = (b == sync1) ? gbfp_pkg::PH_SYNC2 : gbfp_pkg::PH_SYNC1;
                    end
                end
                gbfp_pkg::PH_LEN: begin
                    if (b == gbfp_pkg::LenByte) begin
                        n_phase = gbfp_pkg::PH_PAYLOAD;
                        n_sum_a = b;
                        n_sum_b = b;
                        n_count = '0;
                    end else begin
                        n_phase = (b == sync1) ? gbfp_pkg::PH_SYNC2 : gbfp_pkg::PH_SYNC1;
                    end
                end
                gbfp_pkg::PH_PAYLOAD: begin
                    n_sum_a = r_sum_a + b;
                    n_sum_b = r_sum_b + n_sum_a;
                    n_count = r_count + 1'b1;
                    if (r_count == gbfp_pkg::CountW'(gbfp_pkg::FrameLen - 1)) begin
                        n_phase = gbfp_pkg::PH_CKA;
                    end
                end
                gbfp_pkg::PH_CKA: begin
                    n_phase = (b == r_sum_a) ? gbfp_pkg::PH_CKB : gbfp_pkg::PH_SYNC1;
                end
                gbfp_pkg::PH_CKB: begin
                    n_phase = gbfp_pkg::PH_SYNC1;
                    o_push  = (b == r_sum_b);
                end
                default: begin
                    n_phase = (b == sync1) ? gbfp_pkg::PH_SYNC2 : gbfp_pkg::PH_SYNC1;
                end
            endcase
        end
    end

    always_comb begin
        o_frame.version = i_version;
        o_frame.fix_3d  = (r_store[21] == gbfp_pkg::Fix3dPlain) ||
                          (r_store[21] == gbfp_pkg::Fix3dAug);
        o_frame.lat     = {r_store[3], r_store[2], r_store[1], r_store[0]};
        o_frame.lon     = {r_store[7], r_store[6], r_store[5], r_store[4]};
        o_frame.alt     = {r_store[11], r_store[10], r_store[9], r_store[8]};
        o_frame.speed   = {r_store[15], r_store[14], r_store[13], r_store[12]};
        o_frame.course  = {r_store[19], r_store[18], r_store[17], r_store[16]};
        o_frame.sats    = r_store[20];
        o_frame.utc     = {r_store[29], r_store[28], r_store[27], r_store[26]};
    end

endmodule

/* sv/gbfp_queue.sv */
module gbfp_queue #(
    parameter int unsigned DEPTH = gbfp_pkg::QueueDepth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  gbfp_pkg::t_frame i_frame,
    output logic             o_space,
    output gbfp_pkg::t_frame o_frame,
    output gbfp_pkg::t_hs    o_pop_hs,
    input  logic             i_pop
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    gbfp_pkg::t_frame  r_mem [DEPTH];
    logic [PtrW-1:0]   r_wr, n_wr;
    logic [PtrW-1:0]   r_rd, n_rd;
    logic [CntW-1:0]   r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_space        = (r_cnt != CntW'(DEPTH));
    assign do_push        = i_push && o_space;
    assign do_pop         = i_pop && (r_cnt != '0);
    assign o_frame        = r_mem[r_rd];
    assign o_pop_hs.valid = (r_cnt != '0);
    assign o_pop_hs.ready = i_pop;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

endmodule

/* sv/gbfp_div100.sv */
module gbfp_div100 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_value,
    output logic        o_done,
    output logic [25:0] o_quot
);

    logic        r_neg;
    logic [31:0] r_mag;
    logic        r_stage;
    logic        r_done;
    logic [25:0] r_quot;
    logic [63:0] prod;

    assign prod   = 64'(r_mag) * 64'(gbfp_pkg::Div100Magic);
    assign o_quot = r_neg ? (26'd0 - r_quot) : r_quot;
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= i_start;
            if (i_start) begin
                r_done <= 1'b0;
            end else if (r_stage) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_value[31];
            r_mag <= i_value[31] ? (32'd0 - i_value) : i_value;
        end
        if (r_stage) begin
            r_quot <= prod[gbfp_pkg::Div100Shift +: 26];
        end
    end

endmodule

/* sv/gbfp_back.sv */
module gbfp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gbfp_pkg::t_frame i_frame,
    input  gbfp_pkg::t_hs    i_q_hs,
    output logic             o_pop,
    gbfp_result_if.source    o_result
);

    logic        r_busy;
    logic        r_out_valid;
    logic        pop;
    logic        load;
    logic        alt_done, crs_done;
    logic [25:0] alt_q, crs_q;
    logic [31:0] lat_s, lon_s;

    logic        r_fix;
    logic [31:0] r_lat, r_lon, r_speed, r_utc;
    logic [7:0]  r_sats;

    assign pop   = i_q_hs.valid && !r_busy;
    assign o_pop = pop;
    assign load  = r_busy && alt_done && crs_done && (!r_out_valid || o_result.ready);
    assign lat_s = (i_frame.version == gbfp_pkg::VerV16) ?
                   (i_frame.lat << 3) + (i_frame.lat << 1) : i_frame.lat;
    assign lon_s = (i_frame.version == gbfp_pkg::VerV16) ?
                   (i_frame.lon << 3) + (i_frame.lon << 1) : i_frame.lon;

    gbfp_div100 u_div_alt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (pop),
        .i_value (i_frame.alt),
        .o_done  (alt_done),
        .o_quot  (alt_q)
    );

    gbfp_div100 u_div_crs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (pop),
        .i_value (i_frame.course),
        .o_done  (crs_done),
        .o_quot  (crs_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_busy <= 1'b1;
            end else if (load) begin
                r_busy <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_fix   <= i_frame.fix_3d;
            r_lat   <= lat_s;
            r_lon   <= lon_s;
            r_speed <= i_frame.speed;
            r_sats  <= i_frame.sats;
            r_utc   <= i_frame.utc;
        end
        if (load) begin
            o_result.fix_3d          <= r_fix;
            o_result.latitude        <= r_lat;
            o_result.longitude       <= r_lon;
            o_result.altitude_m      <= alt_q;
            o_result.speed_cms       <= r_speed;
            o_result.course_deg      <= crs_q;
            o_result.satellite_count <= r_sats;
            o_result.utc_word        <= r_utc;
        end
    end

    assign o_result.valid = r_out_valid;

endmodule

/* sv/gps_binary_frame_parser_unit.sv */
// channel   dir  handshake        payload
// i_byte    in   valid/ready      rx_byte[7:0]
// o_result  out  valid/ready      fix_3d, latitude .. utc_word
// apb       in   psel/penable     protocol_version at byte address 0
//
// One byte per cycle in while the queue has space. A frame is queued at the edge
// that takes its last checksum byte; the two-stage reciprocal divide-by-100 units
// in the back end then take it, and take a new frame only once its result loads.
// Reset is synchronous; no clearing pass. Input stalls only when the frame
// queue is full; a stalled output holds one result while the next divides.
module gps_binary_frame_parser_unit #(
    parameter int unsigned QUEUE_DEPTH = gbfp_pkg::QueueDepth
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    gbfp_byte_if.sink                     i_byte,
    gbfp_result_if.source                 o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gbfp_pkg::AddrW-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic             r_version;
    logic             reg_sel;
    logic             q_space;
    logic             push;
    logic             pop;
    gbfp_pkg::t_frame f_frame;
    gbfp_pkg::t_frame q_frame;
    gbfp_pkg::t_hs    q_hs;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[gbfp_pkg::AddrW-1] == gbfp_pkg::RegVer);
    assign prdata  = reg_sel ? {31'd0, r_version} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= gbfp_pkg::VerV19;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_version <= pwdata[0];
        end
    end

    gbfp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_version (r_version),
        .i_byte    (i_byte),
        .i_space   (q_space),
        .o_push    (push),
        .o_frame   (f_frame)
    );

    gbfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_frame  (f_frame),
        .o_space  (q_space),
        .o_frame  (q_frame),
        .o_pop_hs (q_hs),
        .i_pop    (pop)
    );

    gbfp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (q_frame),
        .i_q_hs   (q_hs),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule
